// File: sv/dsws_pkg.sv
package dsws_pkg;

    // Fixed field widths of the channels
    localparam int VAL_W = 16;
    localparam int SUM_W = 20;
    localparam int CNT_W = 5;

    // Sequencer states
    typedef enum logic [2:0] {
        S_LOAD,
        S_RDI,
        S_LDI,
        S_SCAN,
        S_WBI,
        S_ERD,
        S_EWR
    } t_state;

    // Strobes from the sequencer to the statistics and output stage
    typedef struct packed {
        logic load;
        logic emit_load;
        logic emit_final;
    } t_seq_ctl;

endpackage

// File: sv/dsws_if.sv
interface dsws_in_if;
    logic                       valid;
    logic                       ready;
    logic [dsws_pkg::VAL_W-1:0] value;
    logic                       last;

    modport source (output valid, output value, output last, input ready);
    modport sink (input valid, input value, input last, output ready);
endinterface

interface dsws_out_if;
    logic                       valid;
    logic                       ready;
    logic [dsws_pkg::VAL_W-1:0] sorted_value;
    logic                       final_res;
    logic [dsws_pkg::SUM_W-1:0] total_sum;
    logic [dsws_pkg::CNT_W-1:0] even_count;
    logic [dsws_pkg::CNT_W-1:0] odd_count;

    modport source (output valid, output sorted_value, output final_res,
                    output total_sum, output even_count, output odd_count, input ready);
    modport sink (input valid, input sorted_value, input final_res,
                  input total_sum, input even_count, input odd_count, output ready);
endinterface

// File: sv/descending_sort_with_stats_top.sv
// Descending sort with set statistics.
// i_in carries one value per transaction; last marks the final value of a
// set. A set also ends when SET_SIZE values are loaded. Values are taken
// one per cycle while loading. After the set ends the block sorts it in its
// store, a single-port-read RAM: each of the n rows reads its pivot, sweeps
// all n entries at one read per cycle and writes the pivot back. No value is
// taken meanwhile.
// Results leave on o_out largest first, one per transaction. Each result
// takes a RAM read, an output register load and the transaction that frees
// the output register; the next read waits until the register is free.
// The final result carries final_res, total_sum, even_count and odd_count;
// these are zero on the others.
// When the receiver stalls, the result holds in the output register and the
// sequencer waits; the last result of a set may wait while the next set
// loads. Reset (i_rst_n low, synchronous) empties the store and clears the
// sums; store contents are not cleared.
module descending_sort_with_stats_top #(
    parameter int SET_SIZE   = 16,
    parameter int VALUE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dsws_in_if.sink     i_in,
    dsws_out_if.source  o_out
);

    localparam int AW = $clog2(SET_SIZE);
    localparam int CW = $clog2(SET_SIZE + 1);

    dsws_pkg::t_seq_ctl    w_ctl;
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [AW-1:0]         w_raddr;
    logic [VALUE_BITS-1:0] w_wdata;
    logic [VALUE_BITS-1:0] w_rdata;
    logic [VALUE_BITS-1:0] w_value;

    logic [dsws_pkg::SUM_W-1:0] r_sum;
    logic [CW-1:0]              r_even;
    logic [CW-1:0]              r_odd;

    logic                       r_out_valid;
    logic [dsws_pkg::VAL_W-1:0] r_out_value;
    logic                       r_out_final;
    logic [dsws_pkg::SUM_W-1:0] r_out_sum;
    logic [dsws_pkg::CNT_W-1:0] r_out_even;
    logic [dsws_pkg::CNT_W-1:0] r_out_odd;

    // Keep only the stored bits of the value
    assign w_value = VALUE_BITS'(i_in.value);

    dsws_seq #(
        .SET_SIZE   (SET_SIZE),
        .VALUE_BITS (VALUE_BITS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_last     (i_in.last),
        .i_value    (w_value),
        .o_in_ready (i_in.ready),
        .i_out_free (!r_out_valid),
        .o_ctl      (w_ctl),
        .o_we       (w_we),
        .o_waddr    (w_waddr),
        .o_wdata    (w_wdata),
        .o_raddr    (w_raddr),
        .i_rdata    (w_rdata)
    );

    dsws_ram #(
        .DEPTH (SET_SIZE),
        .WIDTH (VALUE_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Accumulate set statistics; clear once the final result is loaded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_even <= '0;
            r_odd  <= '0;
        end else if (w_ctl.emit_load && w_ctl.emit_final) begin
            r_sum  <= '0;
            r_even <= '0;
            r_odd  <= '0;
        end else if (w_ctl.load && i_in.ready) begin
            r_sum  <= r_sum + dsws_pkg::SUM_W'(w_value);
            r_even <= r_even + CW'(!w_value[0]);
            r_odd  <= r_odd + CW'(w_value[0]);
        end
    end

    // Output register valid: set on load, drop when the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.emit_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (w_ctl.emit_load) begin
            r_out_value <= dsws_pkg::VAL_W'(w_rdata);
            r_out_final <= w_ctl.emit_final;
            r_out_sum   <= w_ctl.emit_final ? r_sum : '0;
            r_out_even  <= w_ctl.emit_final ? dsws_pkg::CNT_W'(r_even) : '0;
            r_out_odd   <= w_ctl.emit_final ? dsws_pkg::CNT_W'(r_odd) : '0;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.sorted_value = r_out_value;
    assign o_out.final_res    = r_out_final;
    assign o_out.total_sum    = r_out_sum;
    assign o_out.even_count   = r_out_even;
    assign o_out.odd_count    = r_out_odd;

endmodule

// File: sv/dsws_ram.sv
module dsws_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: sv/dsws_seq.sv
module dsws_seq #(
    parameter int SET_SIZE   = 16,
    parameter int VALUE_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_last,
    input  logic [VALUE_BITS-1:0]       i_value,
    output logic                        o_in_ready,
    input  logic                        i_out_free,
    output dsws_pkg::t_seq_ctl          o_ctl,
    output logic                        o_we,
    output logic [$clog2(SET_SIZE)-1:0] o_waddr,
    output logic [VALUE_BITS-1:0]       o_wdata,
    output logic [$clog2(SET_SIZE)-1:0] o_raddr,
    input  logic [VALUE_BITS-1:0]       i_rdata
);

    localparam int AW = $clog2(SET_SIZE);
    localparam int CW = $clog2(SET_SIZE + 1);

    dsws_pkg::t_state      r_state, n_state;
    logic [CW-1:0]         r_fill, n_fill;
    logic [AW-1:0]         r_i, n_i;
    logic [AW-1:0]         r_j, n_j;
    logic [VALUE_BITS-1:0] r_ai, n_ai;

    logic          w_accept;
    logic [CW-1:0] w_fill_inc;
    logic          w_set_end;
    logic          w_i_last;
    logic          w_j_last;
    logic          w_swap;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_fill_inc = r_fill + CW'(1);
    assign w_set_end  = i_last || (w_fill_inc == CW'(SET_SIZE));
    assign w_i_last   = (CW'(r_i) + CW'(1)) == r_fill;
    assign w_j_last   = (CW'(r_j) + CW'(1)) == r_fill;
    // Row element lives in r_ai, so its own store slot is stale: skip it
    assign w_swap     = (r_j != r_i) && (r_ai > i_rdata);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dsws_pkg::S_LOAD: if (w_accept && w_set_end) n_state = dsws_pkg::S_RDI;
            dsws_pkg::S_RDI:  n_state = dsws_pkg::S_LDI;
            dsws_pkg::S_LDI:  n_state = dsws_pkg::S_SCAN;
            dsws_pkg::S_SCAN: if (w_j_last) n_state = dsws_pkg::S_WBI;
            dsws_pkg::S_WBI:  n_state = w_i_last ? dsws_pkg::S_ERD : dsws_pkg::S_RDI;
            dsws_pkg::S_ERD:  if (i_out_free) n_state = dsws_pkg::S_EWR;
            dsws_pkg::S_EWR:  n_state = w_j_last ? dsws_pkg::S_LOAD : dsws_pkg::S_ERD;
            default:          n_state = dsws_pkg::S_LOAD;
        endcase
    end

    // Memory control and strobes
    always_comb begin
        o_in_ready       = 1'b0;
        o_we             = 1'b0;
        o_waddr          = r_i;
        o_wdata          = r_ai;
        o_raddr          = r_j;
        o_ctl.load       = 1'b0;
        o_ctl.emit_load  = 1'b0;
        o_ctl.emit_final = 1'b0;
        unique case (r_state)
            dsws_pkg::S_LOAD: begin
                o_in_ready = 1'b1;
                o_we       = i_in_valid;
                o_waddr    = r_fill[AW-1:0];
                o_wdata    = i_value;
                o_ctl.load = i_in_valid;
            end
            dsws_pkg::S_RDI: o_raddr = r_i;
            dsws_pkg::S_LDI: o_raddr = '0;
            dsws_pkg::S_SCAN: begin
                o_we    = w_swap;
                o_waddr = r_j;
                o_raddr = r_j + AW'(1);
            end
            dsws_pkg::S_WBI: o_we = 1'b1;
            dsws_pkg::S_ERD: o_raddr = r_j;
            dsws_pkg::S_EWR: begin
                o_ctl.emit_load  = 1'b1;
                o_ctl.emit_final = w_j_last;
            end
            default: ;
        endcase
    end

    // Counters and row element
    always_comb begin
        n_fill = r_fill;
        n_i    = r_i;
        n_j    = r_j;
        n_ai   = r_ai;
        unique case (r_state)
            dsws_pkg::S_LOAD: begin
                if (w_accept) begin
                    n_fill = w_fill_inc;
                    n_i    = '0;
                end
            end
            dsws_pkg::S_RDI: ;
            dsws_pkg::S_LDI: begin
                n_ai = i_rdata;
                n_j  = '0;
            end
            dsws_pkg::S_SCAN: begin
                if (w_swap) n_ai = i_rdata;
                if (!w_j_last) n_j = r_j + AW'(1);
            end
            dsws_pkg::S_WBI: begin
                if (w_i_last) n_j = '0;
                else n_i = r_i + AW'(1);
            end
            dsws_pkg::S_ERD: ;
            dsws_pkg::S_EWR: begin
                if (w_j_last) n_fill = '0;
                else n_j = r_j + AW'(1);
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dsws_pkg::S_LOAD;
            r_fill  <= '0;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

    // Payload register
    always_ff @(posedge i_clk) begin
        r_ai <= n_ai;
    end

    a_ready_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_fill < CW'(SET_SIZE)))
        else $error("load accepted with a full store");

    a_load_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dsws_pkg::S_LOAD) |=>
        (r_state == dsws_pkg::S_LOAD || r_state == dsws_pkg::S_RDI))
        else $error("load left without starting the sort");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dsws_pkg::S_EWR) |-> $past(i_out_free))
        else $error("result loaded into a busy output register");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dsws_pkg::S_SCAN || r_state == dsws_pkg::S_EWR) |->
        (CW'(r_j) < r_fill && CW'(r_i) < r_fill))
        else $error("index beyond the loaded set");

endmodule
